@@ rtl/core/klx_pkg.sv @@
// Shared types, constants and keyword helpers for the keyword and number lexer.
`timescale 1ns / 1ps

package klx_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } klx_in_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [30:0] number_value;
        logic        number_overflow;
    } klx_token_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
        logic       is_word;
        logic       is_digit;
        logic       is_newline;
    } klx_class_t;

    localparam logic [1:0] KIND_MAIN   = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_RETURN = 2'd2;
    localparam logic [1:0] KIND_NUM    = 2'd3;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    localparam logic [2:0] ID_LEN_MAX   = 3'd7;
    localparam logic [2:0] CANDS_ALL    = 3'b111;

    localparam int KLX_QUEUE_DEPTH = 4;
    localparam int KLX_QPTR_BITS   = $clog2(KLX_QUEUE_DEPTH);

    function automatic logic [2:0] klx_kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            KIND_MAIN:   len = 3'd4;
            KIND_INT:    len = 3'd3;
            KIND_RETURN: len = 3'd6;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    // Keyword k still matches after byte c lands at position pos.
    function automatic logic klx_kw_keeps(input logic [1:0] k, input logic [2:0] pos,
                                          input logic [7:0] c);
        logic [47:0] text;
        logic [2:0]  sel;
        logic        keep;
        case (k)
            KIND_MAIN:   text = {"main", 16'h0000};
            KIND_INT:    text = {"int", 24'h000000};
            KIND_RETURN: text = "return";
            default:     text = '0;
        endcase
        sel  = 3'd5 - pos;
        keep = 1'b0;
        if (pos < klx_kw_len(k)) begin
            keep = (text[{sel, 3'b000} +: 8] == c);
        end
        return keep;
    endfunction

    // {found, kind} for the first keyword whose candidate bit and length match.
    function automatic logic [2:0] klx_kw_found(input logic [2:0] len, input logic [2:0] cands);
        logic [2:0] res;
        res = '0;
        if (cands[0] && len == klx_kw_len(KIND_MAIN)) begin
            res = {1'b1, KIND_MAIN};
        end else if (cands[1] && len == klx_kw_len(KIND_INT)) begin
            res = {1'b1, KIND_INT};
        end else if (cands[2] && len == klx_kw_len(KIND_RETURN)) begin
            res = {1'b1, KIND_RETURN};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/keyword_number_lexer.sv @@
// Keyword and decimal number lexer, top level.
//
// s_ channel: one ASCII byte per item (char_byte) with final_byte marking the
// last byte of the source. m_ channel: one token per item carrying its kind
// (main, int, return or number), start line and column, and for numbers the
// value and an overflow flag. Identifiers other than the three keywords and
// all other bytes give no token.
// Throughput: one byte per cycle, sustained, as long as m_ready keeps up.
// A token is presented on m_ from the output register: the front classifies
// the byte ending it into a four-entry queue, and the back scanner reads the
// queue head and loads the output register.
// When the receiver stalls, the output register holds its token, the back end
// stops reading the queue, and s_ready drops once four bytes are queued.
// Reset (aresetn low, synchronous) empties the queue and the output register,
// sets line 1, column 0 and an idle scanner.
`timescale 1ns / 1ps

module keyword_number_lexer #(
    parameter int POSITION_BITS = 16,
    parameter int NUMBER_BITS   = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  klx_pkg::klx_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output klx_pkg::klx_token_t m_data
);
    import klx_pkg::*;

    localparam int QW = $bits(klx_class_t) + 2 * POSITION_BITS;

    logic                     q_full, q_push, q_pop, q_valid;
    klx_class_t               f_class, b_class;
    logic [POSITION_BITS-1:0] f_line, f_column, b_line, b_column;
    logic [QW-1:0]            q_in, q_out;

    klx_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_class  (f_class),
        .q_line   (f_line),
        .q_column (f_column)
    );

    assign q_in = {f_class, f_line, f_column};

    klx_queue #(
        .DATA_BITS(QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    assign {b_class, b_line, b_column} = q_out;

    klx_back #(
        .POSITION_BITS(POSITION_BITS),
        .NUMBER_BITS  (NUMBER_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_class  (b_class),
        .q_line   (b_line),
        .q_column (b_column),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/core/klx_front.sv @@
// Front end: accepts bytes, classifies them and tracks line and column.
`timescale 1ns / 1ps

module klx_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  klx_pkg::klx_in_t         s_data,
    input  logic                     q_full,
    output logic                     q_push,
    output klx_pkg::klx_class_t      q_class,
    output logic [POSITION_BITS-1:0] q_line,
    output logic [POSITION_BITS-1:0] q_column
);
    import klx_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] col_inc;
    logic                     is_letter;
    logic [7:0]               c;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign c       = s_data.char_byte;

    always_comb begin
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        q_class.char_byte  = c;
        q_class.final_byte = s_data.final_byte;
        q_class.is_word    = is_letter || (c == CH_UNDERSCORE);
        q_class.is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        q_class.is_newline = (c == CH_NEWLINE);

        col_inc   = (col_reg == POS_MAX) ? col_reg : col_reg + 1'b1;
        line_next = line_reg;
        col_next  = col_inc;
        if (q_class.is_newline) begin
            if (line_reg != POS_MAX) begin
                line_next = line_reg + 1'b1;
            end
            col_next = '0;
        end
    end

    assign q_line   = line_reg;
    assign q_column = col_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= POSITION_BITS'(1);
            col_reg  <= '0;
        end else if (q_push) begin
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

@@ rtl/core/klx_queue.sv @@
// Small first-in first-out queue between the lexer front and back ends.
`timescale 1ns / 1ps

module klx_queue #(
    parameter int DATA_BITS = 44
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output logic [DATA_BITS-1:0] pop_data
);
    import klx_pkg::*;

    logic [DATA_BITS-1:0]     mem [KLX_QUEUE_DEPTH];
    logic [KLX_QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [KLX_QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [KLX_QPTR_BITS:0]   count_reg, count_next;
    logic                     do_push, do_pop;

    assign full      = (count_reg == (KLX_QPTR_BITS+1)'(KLX_QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/klx_back.sv @@
// Back end: identifier and number scanner with the registered token output.
`timescale 1ns / 1ps

module klx_back #(
    parameter int POSITION_BITS = 16,
    parameter int NUMBER_BITS   = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  klx_pkg::klx_class_t      q_class,
    input  logic [POSITION_BITS-1:0] q_line,
    input  logic [POSITION_BITS-1:0] q_column,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output klx_pkg::klx_token_t      m_data
);
    import klx_pkg::*;

    localparam int AW = NUMBER_BITS - 1;
    localparam int PW = AW + 4;
    localparam logic [AW-1:0] NUM_MAX = '1;

    typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUM} mode_t;

    mode_t                    mode_reg, mode_next, mid_mode;
    logic [2:0]               len_reg, len_next, base_len, mid_len, len_add;
    logic [2:0]               cand_reg, cand_next, base_cand, mid_cand, cand_add;
    logic [AW-1:0]            acc_reg, acc_next, base_acc, mid_acc;
    logic                     ovf_reg, ovf_next, base_ovf, mid_ovf;
    logic [POSITION_BITS-1:0] sline_reg, sline_next, scol_reg, scol_next;
    logic                     out_valid_reg, out_valid_next;
    klx_token_t               out_reg, out_next;

    logic       take, brk, cont_id, cont_num, open, do_id, do_num;
    logic [2:0] found1, found2;
    logic       hit1, hit2, emit;
    logic [3:0] digit;
    logic [PW-1:0] wide, prod;
    klx_token_t tok1, tok2;

    always_comb begin
        take  = q_valid && (!out_valid_reg || m_ready);
        q_pop = take;

        cont_id  = (mode_reg == MODE_IDENT) && (q_class.is_word || q_class.is_digit);
        cont_num = (mode_reg == MODE_NUM) && q_class.is_digit;
        brk      = !cont_id && !cont_num;
        open     = brk && (q_class.is_word || q_class.is_digit);
        do_id    = cont_id || (open && q_class.is_word);
        do_num   = cont_num || (open && !q_class.is_word);

        // token ended by this byte
        found1 = klx_kw_found(len_reg, cand_reg);
        hit1   = brk && ((mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT && found1[2]));
        tok1.token_kind      = (mode_reg == MODE_NUM) ? KIND_NUM : found1[1:0];
        tok1.token_line      = 16'(sline_reg);
        tok1.token_column    = 16'(scol_reg);
        tok1.number_value    = (mode_reg == MODE_NUM) ? 31'(acc_reg) : '0;
        tok1.number_overflow = (mode_reg == MODE_NUM) && ovf_reg;

        base_len  = brk ? 3'd0 : len_reg;
        base_cand = brk ? CANDS_ALL : cand_reg;
        base_acc  = brk ? '0 : acc_reg;
        base_ovf  = brk ? 1'b0 : ovf_reg;

        for (int k = 0; k < 3; k++) begin
            cand_add[k] = base_cand[k] && klx_kw_keeps(2'(k), base_len, q_class.char_byte);
        end
        len_add = (base_len == ID_LEN_MAX) ? base_len : base_len + 1'b1;

        digit = 4'(q_class.char_byte - CH_ZERO);
        wide  = PW'(base_acc);
        prod  = (wide << 3) + (wide << 1) + PW'(digit);

        mid_mode = mode_reg;
        if (brk) begin
            mid_mode = open ? (q_class.is_word ? MODE_IDENT : MODE_NUM) : MODE_IDLE;
        end
        mid_len  = do_id ? len_add : base_len;
        mid_cand = do_id ? cand_add : base_cand;
        mid_acc  = base_acc;
        mid_ovf  = base_ovf;
        if (do_num) begin
            if (prod > PW'(NUM_MAX)) begin
                mid_acc = NUM_MAX;
                mid_ovf = 1'b1;
            end else begin
                mid_acc = prod[AW-1:0];
            end
        end
        sline_next = open ? q_line : sline_reg;
        scol_next  = open ? q_column : scol_reg;

        // flush on the final byte
        found2 = klx_kw_found(mid_len, mid_cand);
        hit2   = q_class.final_byte && !hit1 &&
                 ((mid_mode == MODE_NUM) || (mid_mode == MODE_IDENT && found2[2]));
        tok2.token_kind      = (mid_mode == MODE_NUM) ? KIND_NUM : found2[1:0];
        tok2.token_line      = 16'(sline_next);
        tok2.token_column    = 16'(scol_next);
        tok2.number_value    = (mid_mode == MODE_NUM) ? 31'(mid_acc) : '0;
        tok2.number_overflow = (mid_mode == MODE_NUM) && mid_ovf;

        if (q_class.final_byte) begin
            mode_next = MODE_IDLE;
            len_next  = '0;
            cand_next = CANDS_ALL;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end else begin
            mode_next = mid_mode;
            len_next  = mid_len;
            cand_next = mid_cand;
            acc_next  = mid_acc;
            ovf_next  = mid_ovf;
        end

        emit           = take && (hit1 || hit2);
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (!out_valid_reg || m_ready) begin
            out_valid_next = emit;
            if (emit) begin
                out_next = hit1 ? tok1 : tok2;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            cand_reg      <= CANDS_ALL;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            sline_reg     <= POSITION_BITS'(1);
            scol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                mode_reg  <= mode_next;
                len_reg   <= len_next;
                cand_reg  <= cand_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                sline_reg <= sline_next;
                scol_reg  <= scol_next;
            end
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

endmodule

@@ bench/klx_token_checker.sv @@
// Token checker for the keyword and number lexer: predicts tokens from accepted bytes and compares.
`timescale 1ns / 1ps

module klx_token_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  klx_pkg::klx_in_t    s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  klx_pkg::klx_token_t m_data,
    output int unsigned         mismatches,
    output int unsigned         outstanding
);
    import klx_pkg::*;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_mode_t;

    localparam logic [15:0] POS_LIMIT   = 16'hFFFF;
    localparam logic [63:0] VALUE_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [2:0]  WORD_CAP    = 3'd7;

    scan_mode_t  scan_mode    = SCAN_IDLE;
    logic [2:0]  word_len     = '0;
    logic [2:0]  still_match  = 3'b111;
    logic [63:0] value_acc    = '0;
    logic        value_sat    = 1'b0;
    logic [15:0] cur_line     = 16'd1;
    logic [15:0] cur_col      = '0;
    logic [15:0] tok_line     = 16'd1;
    logic [15:0] tok_col      = '0;
    int unsigned err_count    = 0;

    klx_token_t expected_tokens[$];

    function automatic string keyword_text(input logic [1:0] kind);
        string t;
        case (kind)
            KIND_MAIN: t = "main";
            KIND_INT:  t = "int";
            default:   t = "return";
        endcase
        return t;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            err_count++;
        end
    endfunction

    task automatic close_token(output bit emitted, output klx_token_t tok);
        string kw;
        emitted = 1'b0;
        tok     = '0;
        if (scan_mode == SCAN_WORD) begin
            for (int k = 0; k < 3; k++) begin
                kw = keyword_text(2'(k));
                if (!emitted && still_match[k] && int'(word_len) == kw.len()) begin
                    emitted          = 1'b1;
                    tok.token_kind   = k[1:0];
                    tok.token_line   = tok_line;
                    tok.token_column = tok_col;
                end
            end
        end else if (scan_mode == SCAN_NUMBER) begin
            emitted             = 1'b1;
            tok.token_kind      = KIND_NUM;
            tok.token_line      = tok_line;
            tok.token_column    = tok_col;
            tok.number_value    = value_acc[30:0];
            tok.number_overflow = value_sat;
        end
        scan_mode   = SCAN_IDLE;
        word_len    = '0;
        still_match = 3'b111;
        value_acc   = '0;
        value_sat   = 1'b0;
    endtask

    task automatic add_word_char(input logic [7:0] c);
        string t;
        for (int k = 0; k < 3; k++) begin
            t = keyword_text(2'(k));
            if (int'(word_len) >= t.len() || t[word_len] != c) begin
                still_match[k] = 1'b0;
            end
        end
        if (word_len < WORD_CAP) begin
            word_len++;
        end
    endtask

    task automatic add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c) - 64'(CH_ZERO);
        if (value_acc > (VALUE_LIMIT - d) / 10) begin
            value_acc = VALUE_LIMIT;
            value_sat = 1'b1;
        end else begin
            value_acc = value_acc * 10 + d;
        end
    endtask

    task automatic predict_byte(input klx_in_t item);
        logic [7:0] c;
        bit         is_word;
        bit         is_dig;
        bit         got;
        bit         spare;
        klx_token_t tok;
        klx_token_t junk;
        c       = item.char_byte;
        is_word = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
        is_dig  = (c >= CH_ZERO && c <= CH_NINE);
        got     = 1'b0;
        if (cur_col != POS_LIMIT) begin
            cur_col++;
        end
        if (scan_mode == SCAN_WORD && (is_word || is_dig)) begin
            add_word_char(c);
        end else if (scan_mode == SCAN_NUMBER && is_dig) begin
            add_digit(c);
        end else begin
            close_token(got, tok);
            if (c == CH_NEWLINE) begin
                if (cur_line != POS_LIMIT) begin
                    cur_line++;
                end
                cur_col = '0;
            end else if (is_word || is_dig) begin
                tok_line = cur_line;
                tok_col  = cur_col;
                if (is_word) begin
                    scan_mode = SCAN_WORD;
                    add_word_char(c);
                end else begin
                    scan_mode = SCAN_NUMBER;
                    add_digit(c);
                end
            end
        end
        // final byte flushes; a token already ended by this byte wins
        if (item.final_byte) begin
            if (!got) begin
                close_token(got, tok);
            end else begin
                close_token(spare, junk);
            end
        end
        if (got) begin
            expected_tokens.push_back(tok);
        end
    endtask

    always @(posedge aclk) begin
        klx_token_t want;
        if (!aresetn) begin
            scan_mode   = SCAN_IDLE;
            word_len    = '0;
            still_match = 3'b111;
            value_acc   = '0;
            value_sat   = 1'b0;
            cur_line    = 16'd1;
            cur_col     = '0;
            tok_line    = 16'd1;
            tok_col     = '0;
            expected_tokens.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token: none expected, actual kind %0d line %0d column %0d",
                           m_data.token_kind, m_data.token_line, m_data.token_column);
                    err_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", 32'(want.token_kind), 32'(m_data.token_kind));
                    check_field("token_line", 32'(want.token_line), 32'(m_data.token_line));
                    check_field("token_column", 32'(want.token_column),
                                32'(m_data.token_column));
                    check_field("number_value", 32'(want.number_value),
                                32'(m_data.number_value));
                    check_field("number_overflow", 32'(want.number_overflow),
                                32'(m_data.number_overflow));
                end
            end
            if (s_valid && s_ready) begin
                predict_byte(s_data);
            end
        end
        mismatches  <= err_count;
        outstanding <= expected_tokens.size();
    end

endmodule

@@ bench/tb_keyword_number_lexer.sv @@
// Testbench top for the keyword and number lexer: byte stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_keyword_number_lexer;
    import klx_pkg::*;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    klx_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    klx_token_t  m_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 69;
    int unsigned hold_left   = 100;

    logic [7:0] frag[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    keyword_number_lexer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    klx_token_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stalls plus occasional long hold-offs
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            if (rx_idle_pct != 0 && $urandom_range(0, 499) == 0) begin
                hold_left <= $urandom_range(40, 90);
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {c, fin};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], fin_last && i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = 8'("A" + $urandom_range(0, 25));
            1:       c = CH_UNDERSCORE;
            default: c = 8'("a" + $urandom_range(0, 25));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        string seps;
        seps = " \n\t;(),+";
        return seps[$urandom_range(0, seps.len() - 1)];
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            frag.push_back(s[i]);
        end
    endtask

    task automatic make_fragment();
        int unsigned n;
        frag.delete();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 2))
                    0:       push_text("main");
                    1:       push_text("int");
                    default: push_text("return");
                endcase
                case ($urandom_range(0, 7))
                    0: frag[$urandom_range(0, frag.size() - 1)] = word_char();
                    1: frag.push_back(word_char());
                    2: frag.push_back(digit_char());
                    3: void'(frag.pop_back());
                    default: ;
                endcase
            end
            3, 4: begin
                n = $urandom_range(1, 10);
                frag.push_back(word_char());
                for (int i = 1; i < n; i++) begin
                    frag.push_back($urandom_range(0, 3) == 0 ? digit_char() : word_char());
                end
            end
            5, 6: begin
                case ($urandom_range(0, 5))
                    0: push_text("2147483647");
                    1: push_text("2147483648");
                    2: begin
                        push_text("214748364");
                        frag.push_back(digit_char());
                    end
                    default: begin
                        n = $urandom_range(1, 12);
                        repeat (n) frag.push_back(digit_char());
                    end
                endcase
            end
            7: begin
                n = $urandom_range(1, 3);
                repeat (n) frag.push_back(sep_char());
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) frag.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if ($urandom_range(0, 3) != 0) begin
            frag.push_back(sep_char());
        end
    endtask

    initial begin
        int unsigned sent;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("main int\treturn 0;", 1'b0);
        send_text("9a", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 17;
                    rx_idle_pct = 69;
                end
                1: begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 17;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 650) begin
                make_fragment();
                foreach (frag[i]) begin
                    send_byte(frag[i], $urandom_range(0, 24) == 0);
                end
                sent += frag.size();
            end
        end

        send_text("main 42 return", 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_text("int 7", 1'b1);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/klx_pkg.sv
rtl/core/klx_front.sv
rtl/core/klx_queue.sv
rtl/core/klx_back.sv
rtl/core/keyword_number_lexer.sv
bench/klx_token_checker.sv
bench/tb_keyword_number_lexer.sv
